// ----- rtl/dpb_pkg.sv -----
// ----------------------------------------------------------------------------
// dpb_pkg
// shared widths, register indexes and reset values of the depth pixel
// back-projection unit
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

    // field widths
    localparam int unsigned COL_W   = 10;
    localparam int unsigned ROW_W   = 10;
    localparam int unsigned DEPTH_W = 16;
    localparam int unsigned WORLD_W = 24;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_FX_RECIP  = 3'd0;
    localparam t_cfg_idx CFG_FY_RECIP  = 3'd1;
    localparam t_cfg_idx CFG_CENTER_C  = 3'd2;
    localparam t_cfg_idx CFG_CENTER_R  = 3'd3;
    localparam t_cfg_idx CFG_ROT_ROW0  = 3'd4;
    localparam t_cfg_idx CFG_ROT_ROW1  = 3'd5;
    localparam t_cfg_idx CFG_ROT_ROW2  = 3'd6;
    localparam t_cfg_idx CFG_TRANS_XYZ = 3'd7;

    // register widths
    localparam int unsigned RECIP_W  = 24;
    localparam int unsigned CENTER_W = 14;
    localparam int unsigned ROT_E_W  = 16;
    localparam int unsigned ROT_W    = 3 * ROT_E_W;
    localparam int unsigned TRANS_E_W = 21;
    localparam int unsigned TRANS_W  = 3 * TRANS_E_W;
    localparam int unsigned NUM_AXES = 3;

    // reset values
    localparam logic [RECIP_W-1:0]  FX_RECIP_RST = 24'd31330;
    localparam logic [RECIP_W-1:0]  FY_RECIP_RST = 24'd31115;
    localparam logic [CENTER_W-1:0] CENTER_C_RST = 14'd5122;
    localparam logic [CENTER_W-1:0] CENTER_R_RST = 14'd3962;
    localparam logic [ROT_W-1:0]    ROT_ROW0_RST = 48'h0000_0000_4000;
    localparam logic [ROT_W-1:0]    ROT_ROW1_RST = 48'h0000_4000_0000;
    localparam logic [ROT_W-1:0]    ROT_ROW2_RST = 48'h4000_0000_0000;
    localparam logic [TRANS_W-1:0]  TRANS_RST    = '0;

    // default depth limit, 2 m in 0.2 mm units
    localparam int unsigned MAX_DEPTH_RAW_DEF = 10000;

endpackage : dpb_pkg

`default_nettype wire

// ----- rtl/dpb_if.sv -----
// ----------------------------------------------------------------------------
// dpb interfaces
// request channels of the depth pixel back-projection unit: pixel in,
// world point out, register write
// ----------------------------------------------------------------------------
`default_nettype none

interface dpb_pix_if;
    import dpb_pkg::*;

    logic               valid;
    logic               ready;
    logic [COL_W-1:0]   pixel_col;
    logic [ROW_W-1:0]   pixel_row;
    logic [DEPTH_W-1:0] depth_raw;

    modport source (output valid, pixel_col, pixel_row, depth_raw, input ready);
    modport sink   (input valid, pixel_col, pixel_row, depth_raw, output ready);
endinterface : dpb_pix_if

interface dpb_pt_if;
    import dpb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [WORLD_W-1:0] world_x;
    logic signed [WORLD_W-1:0] world_y;
    logic signed [WORLD_W-1:0] world_z;

    modport source (output valid, world_x, world_y, world_z, input ready);
    modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface : dpb_pt_if

interface dpb_cfg_if;
    import dpb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface : dpb_cfg_if

`default_nettype wire

// ----- rtl/depth_pixel_backprojection_unit.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit
// back-projects depth pixels through pinhole intrinsics and a camera-to-world
// pose, emitting saturated world points in 0.2 mm units
// ----------------------------------------------------------------------------
// pipelined from pixel to point request; one multiply, add or saturate step per stage
// throughput: one pixel per cycle unless a full pipeline stalls; each stage stalls on
//   its own, so bubbles close up while a finished point waits at the output register
// pixels with zero depth or depth above the limit leave no point
// reset (synchronous, active low) empties the pipeline and loads the default
//   intrinsics, identity rotation and zero translation
`default_nettype none

module depth_pixel_backprojection_unit #(
    parameter int unsigned MAX_DEPTH_RAW = dpb_pkg::MAX_DEPTH_RAW_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dpb_cfg_if.sink    i_cfg,
    dpb_pix_if.sink    i_pix,
    dpb_pt_if.source   o_pt
);

    import dpb_pkg::*;

    localparam int unsigned NSTG = 8;
    localparam logic [DEPTH_W-1:0] MaxDepth = DEPTH_W'(MAX_DEPTH_RAW);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [RECIP_W-1:0]  r_fx_recip;
    logic [RECIP_W-1:0]  r_fy_recip;
    logic [CENTER_W-1:0] r_center_c;
    logic [CENTER_W-1:0] r_center_r;
    logic [ROT_W-1:0]    r_rot [NUM_AXES];
    logic [TRANS_W-1:0]  r_trans;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx_recip <= FX_RECIP_RST;
            r_fy_recip <= FY_RECIP_RST;
            r_center_c <= CENTER_C_RST;
            r_center_r <= CENTER_R_RST;
            r_rot[0]   <= ROT_ROW0_RST;
            r_rot[1]   <= ROT_ROW1_RST;
            r_rot[2]   <= ROT_ROW2_RST;
            r_trans    <= TRANS_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FX_RECIP:  r_fx_recip <= i_cfg.data[RECIP_W-1:0];
                CFG_FY_RECIP:  r_fy_recip <= i_cfg.data[RECIP_W-1:0];
                CFG_CENTER_C:  r_center_c <= i_cfg.data[CENTER_W-1:0];
                CFG_CENTER_R:  r_center_r <= i_cfg.data[CENTER_W-1:0];
                CFG_ROT_ROW0:  r_rot[0]   <= i_cfg.data[ROT_W-1:0];
                CFG_ROT_ROW1:  r_rot[1]   <= i_cfg.data[ROT_W-1:0];
                CFG_ROT_ROW2:  r_rot[2]   <= i_cfg.data[ROT_W-1:0];
                CFG_TRANS_XYZ: r_trans    <= i_cfg.data[TRANS_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: per-stage valid, stage advances when empty or
    // when the stage after it advances
    // ------------------------------------------------------------------
    logic [NSTG:1]   r_vld;
    logic [NSTG:1]   n_vld;
    logic [NSTG+1:1] w_adv;
    logic            w_keep;

    assign w_keep = (i_pix.depth_raw != '0) && (i_pix.depth_raw <= MaxDepth);

    always_comb begin
        w_adv[NSTG+1] = o_pt.ready;
        for (int k = NSTG; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld[1] = w_adv[1] ? (i_pix.valid && w_keep) : r_vld[1];
        for (int k = 2; k <= NSTG; k++) begin
            n_vld[k] = w_adv[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_pix.ready = w_adv[1];

    // ------------------------------------------------------------------
    // stage 1: offsets from the principal point, sign and magnitude
    // ------------------------------------------------------------------
    logic signed [CENTER_W:0] n1_dc;
    logic signed [CENTER_W:0] n1_dr;
    logic [CENTER_W-1:0]      n1_dcm;
    logic [CENTER_W-1:0]      n1_drm;
    logic [DEPTH_W-1:0]       r1_depth;
    logic [CENTER_W-1:0]      r1_dcm;
    logic [CENTER_W-1:0]      r1_drm;
    logic                     r1_dcn;
    logic                     r1_drn;

    always_comb begin
        n1_dc  = $signed({1'b0, i_pix.pixel_col, 4'b0}) - $signed({1'b0, r_center_c});
        n1_dr  = $signed({1'b0, i_pix.pixel_row, 4'b0}) - $signed({1'b0, r_center_r});
        n1_dcm = n1_dc[CENTER_W] ? CENTER_W'(-n1_dc) : n1_dc[CENTER_W-1:0];
        n1_drm = n1_dr[CENTER_W] ? CENTER_W'(-n1_dr) : n1_dr[CENTER_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_depth <= i_pix.depth_raw;
            r1_dcm   <= n1_dcm;
            r1_drm   <= n1_drm;
            r1_dcn   <= n1_dc[CENTER_W];
            r1_drn   <= n1_dr[CENTER_W];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: depth times focal reciprocals
    // ------------------------------------------------------------------
    localparam int unsigned DF_W = DEPTH_W + RECIP_W;

    logic [DF_W-1:0]     r2_dfx;
    logic [DF_W-1:0]     r2_dfy;
    logic [DEPTH_W-1:0]  r2_depth;
    logic [CENTER_W-1:0] r2_dcm;
    logic [CENTER_W-1:0] r2_drm;
    logic                r2_dcn;
    logic                r2_drn;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_dfx   <= {{RECIP_W{1'b0}}, r1_depth} * {{DEPTH_W{1'b0}}, r_fx_recip};
            r2_dfy   <= {{RECIP_W{1'b0}}, r1_depth} * {{DEPTH_W{1'b0}}, r_fy_recip};
            r2_depth <= r1_depth;
            r2_dcm   <= r1_dcm;
            r2_drm   <= r1_drm;
            r2_dcn   <= r1_dcn;
            r2_drn   <= r1_drn;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: times the offset magnitude
    // ------------------------------------------------------------------
    localparam int unsigned PM_W = DF_W + CENTER_W;

    logic [PM_W-1:0]    r3_pmx;
    logic [PM_W-1:0]    r3_pmy;
    logic [DEPTH_W-1:0] r3_depth;
    logic               r3_xn;
    logic               r3_yn;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_pmx   <= {{CENTER_W{1'b0}}, r2_dfx} * {{DF_W{1'b0}}, r2_dcm};
            r3_pmy   <= {{CENTER_W{1'b0}}, r2_dfy} * {{DF_W{1'b0}}, r2_drm};
            r3_depth <= r2_depth;
            r3_xn    <= r2_dcn;
            r3_yn    <= r2_drn;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: round the magnitude by 2^28, then restore the sign
    // ------------------------------------------------------------------
    localparam int unsigned CAM_SH = 28;
    localparam int unsigned Q_W    = PM_W + 1 - CAM_SH;
    localparam int unsigned CAM_W  = Q_W + 1;

    logic [PM_W:0]            n4_sx;
    logic [PM_W:0]            n4_sy;
    logic signed [CAM_W-1:0]  n4_qx;
    logic signed [CAM_W-1:0]  n4_qy;
    logic signed [CAM_W-1:0]  r4_xc;
    logic signed [CAM_W-1:0]  r4_yc;
    logic [DEPTH_W-1:0]       r4_depth;

    always_comb begin
        n4_sx = {1'b0, r3_pmx} + ({{PM_W{1'b0}}, 1'b1} << (CAM_SH - 1));
        n4_sy = {1'b0, r3_pmy} + ({{PM_W{1'b0}}, 1'b1} << (CAM_SH - 1));
        n4_qx = $signed({1'b0, n4_sx[PM_W:CAM_SH]});
        n4_qy = $signed({1'b0, n4_sy[PM_W:CAM_SH]});
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_xc    <= r3_xn ? -n4_qx : n4_qx;
            r4_yc    <= r3_yn ? -n4_qy : n4_qy;
            r4_depth <= r3_depth;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: rotation products, one per matrix entry
    // ------------------------------------------------------------------
    localparam int unsigned PR_W = ROT_E_W + CAM_W;

    logic signed [DEPTH_W:0]  w5_zc;
    logic signed [ROT_E_W-1:0] w5_e [NUM_AXES][NUM_AXES];
    logic signed [PR_W-1:0]   n5_p [NUM_AXES][NUM_AXES];
    logic signed [PR_W-1:0]   r5_p [NUM_AXES][NUM_AXES];

    assign w5_zc = $signed({1'b0, r4_depth});

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                w5_e[i][k] = $signed(r_rot[i][ROT_E_W*k +: ROT_E_W]);
            end
            n5_p[i][0] = w5_e[i][0] * r4_xc;
            n5_p[i][1] = w5_e[i][1] * r4_yc;
            n5_p[i][2] = PR_W'(w5_e[i][2] * w5_zc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_p <= n5_p;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: row sums
    // ------------------------------------------------------------------
    localparam int unsigned ACC_W = PR_W + 2;

    logic signed [ACC_W-1:0] n6_acc [NUM_AXES];
    logic signed [ACC_W-1:0] r6_acc [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            n6_acc[i] = ACC_W'(r5_p[i][0]) + ACC_W'(r5_p[i][1]) + ACC_W'(r5_p[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_acc <= n6_acc;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: round by 2^14, ties away from zero, add translation
    // ------------------------------------------------------------------
    localparam int unsigned ROT_SH = 14;
    localparam int unsigned RND_W  = ACC_W - ROT_SH;
    localparam int unsigned SUM_W  = RND_W + 2;

    logic signed [ACC_W-1:0]     w7_bias [NUM_AXES];
    logic signed [ACC_W-1:0]     w7_sum  [NUM_AXES];
    logic signed [RND_W-1:0]     w7_rnd  [NUM_AXES];
    logic signed [TRANS_E_W-1:0] w7_t    [NUM_AXES];
    logic signed [SUM_W-1:0]     n7_w    [NUM_AXES];
    logic signed [SUM_W-1:0]     r7_w    [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            // negative values round half toward minus infinity via bias - 1
            w7_bias[i] = r6_acc[i][ACC_W-1]
                ? $signed(({{(ACC_W-1){1'b0}}, 1'b1} << (ROT_SH - 1)) - {{(ACC_W-1){1'b0}}, 1'b1})
                : $signed({{(ACC_W-1){1'b0}}, 1'b1} << (ROT_SH - 1));
            w7_sum[i]  = r6_acc[i] + w7_bias[i];
            w7_rnd[i]  = $signed(w7_sum[i][ACC_W-1:ROT_SH]);
            w7_t[i]    = $signed(r_trans[TRANS_E_W*i +: TRANS_E_W]);
            n7_w[i]    = SUM_W'(w7_rnd[i]) + SUM_W'(w7_t[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r7_w <= n7_w;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: saturate into the output register
    // ------------------------------------------------------------------
    logic signed [WORLD_W-1:0] n8_out [NUM_AXES];
    logic signed [WORLD_W-1:0] r8_out [NUM_AXES];

    always_comb begin
        for (int i = 0; i < NUM_AXES; i++) begin
            // fits when all bits above the output msb copy the sign
            if (r7_w[i][SUM_W-1:WORLD_W-1] == '0 || r7_w[i][SUM_W-1:WORLD_W-1] == '1) begin
                n8_out[i] = r7_w[i][WORLD_W-1:0];
            end else if (r7_w[i][SUM_W-1]) begin
                n8_out[i] = {1'b1, {(WORLD_W-1){1'b0}}};
            end else begin
                n8_out[i] = {1'b0, {(WORLD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            r8_out <= n8_out;
        end
    end

    assign o_pt.valid   = r_vld[NSTG];
    assign o_pt.world_x = r8_out[0];
    assign o_pt.world_y = r8_out[1];
    assign o_pt.world_z = r8_out[2];

`ifndef SYNTHESIS
    // an empty output stage never holds back the pixel side
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG] |-> i_pix.ready)
        else $error("pixel request blocked with empty output stage");

    // out-of-range depth leaves no item in the pipeline
    a_drop_bad_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && !w_keep) |=> !r_vld[1])
        else $error("dropped pixel entered the pipeline");

    // in-range depth always enters stage one
    a_take_good_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready && w_keep) |=> r_vld[1])
        else $error("accepted pixel lost at pipeline entry");

    // a stalled mid-pipeline stage keeps its item
    a_mid_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[4] && !w_adv[4]) |=> r_vld[4])
        else $error("stalled stage lost its item");
`endif

endmodule : depth_pixel_backprojection_unit

`default_nettype wire

// ----- tb/sv/dpb_world_point_checker.sv -----
// ----------------------------------------------------------------------------
// dpb_world_point_checker
// watches the register, pixel and world point channels of the depth pixel
// back-projection unit, predicts each world point from its own copy of the
// intrinsics and pose, and compares every accepted point field by field
// ----------------------------------------------------------------------------
module dpb_world_point_checker #(
    parameter int unsigned MAX_DEPTH_RAW = dpb_pkg::MAX_DEPTH_RAW_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dpb_cfg_if        i_cfg,
    dpb_pix_if        i_pix,
    dpb_pt_if         i_pt,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dpb_pkg::*;

    localparam longint WORLD_MAX = (longint'(1) <<< (WORLD_W - 1)) - 1;
    localparam longint WORLD_MIN = -(longint'(1) <<< (WORLD_W - 1));

    typedef struct packed {
        logic signed [WORLD_W-1:0] x;
        logic signed [WORLD_W-1:0] y;
        logic signed [WORLD_W-1:0] z;
    } t_world_pt;

    // shadow of the intrinsics and pose
    logic [RECIP_W-1:0]  fx_recip;
    logic [RECIP_W-1:0]  fy_recip;
    logic [CENTER_W-1:0] ctr_col;
    logic [CENTER_W-1:0] ctr_row;
    logic [ROT_W-1:0]    rot_row [NUM_AXES];
    logic [TRANS_W-1:0]  trans_xyz;

    t_world_pt expected_pts [$];

    // divide by 2^s, nearest, ties away from zero
    function automatic longint round_shift(longint v, int unsigned s);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) <<< (s - 1))) >>> s;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint camera_offset(logic [COL_W-1:0] pixel,
                                             logic [CENTER_W-1:0] center,
                                             logic [RECIP_W-1:0] recip,
                                             logic [DEPTH_W-1:0] depth);
        longint delta;
        delta = longint'(pixel) * 16 - longint'(center);
        return round_shift(longint'(depth) * longint'(recip) * delta, 28);
    endfunction

    function automatic logic signed [WORLD_W-1:0] world_axis(int unsigned axis,
                                                            longint xc,
                                                            longint yc,
                                                            longint zc);
        logic [ROT_W-1:0] r;
        longint acc;
        longint w;
        r = rot_row[axis];
        acc = longint'($signed(r[15:0])) * xc
            + longint'($signed(r[31:16])) * yc
            + longint'($signed(r[47:32])) * zc;
        w = round_shift(acc, 14)
          + longint'($signed(trans_xyz[TRANS_E_W*axis +: TRANS_E_W]));
        if (w > WORLD_MAX) w = WORLD_MAX;
        if (w < WORLD_MIN) w = WORLD_MIN;
        return w[WORLD_W-1:0];
    endfunction

    function automatic t_world_pt project_to_world(logic [COL_W-1:0] col,
                                                   logic [ROW_W-1:0] row,
                                                   logic [DEPTH_W-1:0] depth);
        t_world_pt p;
        longint xc;
        longint yc;
        xc = camera_offset(col, ctr_col, fx_recip, depth);
        yc = camera_offset(row, ctr_row, fy_recip, depth);
        p.x = world_axis(0, xc, yc, longint'(depth));
        p.y = world_axis(1, xc, yc, longint'(depth));
        p.z = world_axis(2, xc, yc, longint'(depth));
        return p;
    endfunction

    function automatic int field_mismatch(string name,
                                          logic signed [WORLD_W-1:0] want,
                                          logic signed [WORLD_W-1:0] got);
        if (want === got) return 0;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_world_pt want;
        if (!i_rst_n) begin
            fx_recip   <= FX_RECIP_RST;
            fy_recip   <= FY_RECIP_RST;
            ctr_col    <= CENTER_C_RST;
            ctr_row    <= CENTER_R_RST;
            rot_row[0] <= ROT_ROW0_RST;
            rot_row[1] <= ROT_ROW1_RST;
            rot_row[2] <= ROT_ROW2_RST;
            trans_xyz  <= TRANS_RST;
            expected_pts.delete();
            o_fail_count = 0;
            o_pending   <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_FX_RECIP:  fx_recip   <= i_cfg.data[RECIP_W-1:0];
                    CFG_FY_RECIP:  fy_recip   <= i_cfg.data[RECIP_W-1:0];
                    CFG_CENTER_C:  ctr_col    <= i_cfg.data[CENTER_W-1:0];
                    CFG_CENTER_R:  ctr_row    <= i_cfg.data[CENTER_W-1:0];
                    CFG_ROT_ROW0:  rot_row[0] <= i_cfg.data[ROT_W-1:0];
                    CFG_ROT_ROW1:  rot_row[1] <= i_cfg.data[ROT_W-1:0];
                    CFG_ROT_ROW2:  rot_row[2] <= i_cfg.data[ROT_W-1:0];
                    CFG_TRANS_XYZ: trans_xyz  <= i_cfg.data[TRANS_W-1:0];
                    default: ;
                endcase
            end

            // zero depth and depth past the limit leave no point
            if (i_pix.valid && i_pix.ready && i_pix.depth_raw != 0
                    && i_pix.depth_raw <= MAX_DEPTH_RAW)
                expected_pts.insert(expected_pts.size(),
                                    project_to_world(i_pix.pixel_col,
                                                     i_pix.pixel_row,
                                                     i_pix.depth_raw));

            if (i_pt.valid && i_pt.ready) begin
                if (expected_pts.size() == 0) begin
                    $display("%0t: point expected none got x %0d y %0d z %0d", $time,
                             i_pt.world_x, i_pt.world_y, i_pt.world_z);
                    o_fail_count++;
                end else begin
                    want = expected_pts.pop_front();
                    o_fail_count += field_mismatch("world_x", want.x, i_pt.world_x);
                    o_fail_count += field_mismatch("world_y", want.y, i_pt.world_y);
                    o_fail_count += field_mismatch("world_z", want.z, i_pt.world_z);
                end
            end
            o_pending <= expected_pts.size();
        end
    end

endmodule : dpb_world_point_checker

// ----- tb/sv/depth_pixel_backprojection_unit_tb.sv -----
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_unit_tb
// drives depth pixels and register writes into the back-projection unit
// under random idling on the pixel and point channels, with a checker beside the block
// predicting and comparing every world point
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpb_pkg::*;

    localparam int unsigned MAX_DEPTH    = MAX_DEPTH_RAW_DEF;
    localparam int unsigned SETTLE       = 24;       // pipeline is 8 deep
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned HOLD_AFTER   = 60;       // results before the long hold
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned RAND_PER_SET = 46;

    typedef enum int unsigned {
        POSE_DEFAULT,
        POSE_HIGH,
        POSE_LOW,
        POSE_PLAUSIBLE,
        POSE_SCRAMBLED
    } t_pose_kind;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   cycle_count;

    // sink side pacing
    int   stall_left;
    int   run_left;
    int   results_seen;
    bit   held_long;

    bit   no_gaps;
    logic [CFG_DATA_W-1:0] reg_val [8];

    dpb_cfg_if cfg_if ();
    dpb_pix_if pix_if ();
    dpb_pt_if  pt_if ();

    depth_pixel_backprojection_unit #(
        .MAX_DEPTH_RAW (MAX_DEPTH)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_pt    (pt_if)
    );

    dpb_world_point_checker #(
        .MAX_DEPTH_RAW (MAX_DEPTH)
    ) world_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg        (cfg_if),
        .i_pix        (pix_if),
        .i_pt         (pt_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk) begin
        if (!rst_n) begin
            pt_if.ready <= 1'b0;
            stall_left = 0;
            run_left = 0;
            results_seen = 0;
            held_long = 1'b0;
        end else begin
            if (pt_if.valid && pt_if.ready) results_seen++;
            // one long hold-off so the pipeline backs up into the pixel side
            if (!held_long && results_seen >= HOLD_AFTER) begin
                held_long = 1'b1;
                stall_left = LONG_HOLD;
            end
            if (stall_left == 0 && run_left == 0) begin
                run_left = $urandom_range(1, 40);
                stall_left = pick_gap();
            end
            if (stall_left != 0) begin
                pt_if.ready <= 1'b0;
                stall_left--;
            end else begin
                pt_if.ready <= 1'b1;
                run_left--;
            end
        end
    end

    initial begin
        cycle_count = 0;
        @(posedge rst_n);
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL depth_pixel_backprojection_unit");
        $finish;
    end

    // caller sits on a rising edge; returns on the edge of acceptance or after the gap
    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [DEPTH_W-1:0] depth);
        int unsigned gap;
        pix_if.valid     <= 1'b1;
        pix_if.pixel_col <= col;
        pix_if.pixel_row <= row;
        pix_if.depth_raw <= depth;
        @(posedge clk);
        while (!pix_if.ready) @(posedge clk);
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random(int unsigned n_kept);
        int unsigned kept;
        int unsigned r;
        logic [DEPTH_W-1:0] depth;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        kept = 0;
        while (kept < n_kept) begin
            r = $urandom_range(0, 99);
            if (r < 6) depth = '0;
            else if (r < 12) depth = DEPTH_W'($urandom_range(MAX_DEPTH + 1, 65535));
            else if (r == 12) depth = DEPTH_W'(MAX_DEPTH);
            else if (r == 13) depth = DEPTH_W'(1);
            else if (r == 14) depth = DEPTH_W'(MAX_DEPTH + 1);
            else depth = DEPTH_W'($urandom_range(1, MAX_DEPTH));
            col = COL_W'($urandom);
            row = ROW_W'($urandom);
            if ($urandom_range(0, 9) == 0) col = $urandom_range(0, 1) ? '1 : '0;
            if ($urandom_range(0, 9) == 0) row = $urandom_range(0, 1) ? '1 : '0;
            if (depth != 0 && depth <= MAX_DEPTH) kept++;
            send_pixel(col, row, depth);
        end
        pix_if.valid <= 1'b0;
    endtask

    task automatic choose_config(t_pose_kind kind);
        logic [ROT_W-1:0] rot;
        case (kind)
            POSE_DEFAULT: begin
                reg_val[CFG_FX_RECIP]  = FX_RECIP_RST;
                reg_val[CFG_FY_RECIP]  = FY_RECIP_RST;
                reg_val[CFG_CENTER_C]  = CENTER_C_RST;
                reg_val[CFG_CENTER_R]  = CENTER_R_RST;
                reg_val[CFG_ROT_ROW0]  = ROT_ROW0_RST;
                reg_val[CFG_ROT_ROW1]  = ROT_ROW1_RST;
                reg_val[CFG_ROT_ROW2]  = ROT_ROW2_RST;
                reg_val[CFG_TRANS_XYZ] = TRANS_RST;
            end
            POSE_HIGH: begin
                // largest gains and extreme pose, drives saturation both ways
                reg_val[CFG_FX_RECIP]  = {RECIP_W{1'b1}};
                reg_val[CFG_FY_RECIP]  = {RECIP_W{1'b1}};
                reg_val[CFG_CENTER_C]  = '0;
                reg_val[CFG_CENTER_R]  = '0;
                reg_val[CFG_ROT_ROW0]  = {16'h7fff, 16'h7fff, 16'h7fff};
                reg_val[CFG_ROT_ROW1]  = {16'h8000, 16'h8000, 16'h8000};
                reg_val[CFG_ROT_ROW2]  = {16'h7fff, 16'h8000, 16'h7fff};
                reg_val[CFG_TRANS_XYZ] = {21'h0fffff, 21'h100000, 21'h0fffff};
            end
            POSE_LOW: begin
                reg_val[CFG_FX_RECIP]  = '0;
                reg_val[CFG_FY_RECIP]  = '0;
                reg_val[CFG_CENTER_C]  = {CENTER_W{1'b1}};
                reg_val[CFG_CENTER_R]  = {CENTER_W{1'b1}};
                reg_val[CFG_ROT_ROW0]  = '0;
                reg_val[CFG_ROT_ROW1]  = {ROT_W{1'b1}};
                reg_val[CFG_ROT_ROW2]  = '0;
                reg_val[CFG_TRANS_XYZ] = {21'h100000, 21'h0fffff, 21'h000000};
            end
            POSE_PLAUSIBLE: begin
                reg_val[CFG_FX_RECIP] = $urandom_range(25000, 40000);
                reg_val[CFG_FY_RECIP] = $urandom_range(25000, 40000);
                reg_val[CFG_CENTER_C] = $urandom_range(0, 16383);
                reg_val[CFG_CENTER_R] = $urandom_range(0, 16383);
                for (int a = 0; a < NUM_AXES; a++) begin
                    for (int k = 0; k < NUM_AXES; k++)
                        rot[ROT_E_W*k +: ROT_E_W] = 16'($urandom_range(0, 32768) - 16384);
                    reg_val[CFG_ROT_ROW0 + a] = rot;
                end
                reg_val[CFG_TRANS_XYZ] = {21'($urandom_range(0, 200000) - 100000),
                                          21'($urandom_range(0, 200000) - 100000),
                                          21'($urandom_range(0, 200000) - 100000)};
            end
            default: begin
                for (int i = 0; i < 8; i++) reg_val[i] = {$urandom, $urandom};
            end
        endcase
    endtask

    // writes every register, junk above each register's width
    task automatic write_regs();
        int unsigned w;
        logic [CFG_DATA_W-1:0] mask;
        // one edge first so the pending count includes the last pixel request
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        for (int i = 0; i < 8; i++) begin
            case (t_cfg_idx'(i))
                CFG_FX_RECIP, CFG_FY_RECIP: w = RECIP_W;
                CFG_CENTER_C, CFG_CENTER_R: w = CENTER_W;
                CFG_TRANS_XYZ:              w = TRANS_W;
                default:                    w = ROT_W;
            endcase
            mask = (64'd1 << w) - 1;
            cfg_if.valid <= 1'b1;
            cfg_if.index <= t_cfg_idx'(i);
            cfg_if.data  <= (reg_val[i] & mask) | ({$urandom, $urandom} & ~mask);
            @(posedge clk);
            while (!cfg_if.ready) @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        t_pose_kind pose_seq [7];
        pose_seq = '{POSE_HIGH, POSE_LOW, POSE_PLAUSIBLE, POSE_SCRAMBLED,
                     POSE_PLAUSIBLE, POSE_SCRAMBLED, POSE_DEFAULT};
        clk = 1'b0;
        rst_n = 1'b0;
        no_gaps = 1'b0;
        pix_if.valid = 1'b0;
        pix_if.pixel_col = '0;
        pix_if.pixel_row = '0;
        pix_if.depth_raw = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset intrinsics: field extremes, depth limits, invalid depth
        send_pixel(0, 0, 1);
        send_pixel('1, '1, DEPTH_W'(MAX_DEPTH));
        send_pixel(0, '1, DEPTH_W'(MAX_DEPTH + 1));
        send_pixel('1, 0, 0);
        send_pixel(0, 0, '1);
        send_pixel(320, 247, 5000);
        send_pixel(512, 384, 16'h8000);
        send_pixel(640, 480, 2500);
        send_pixel(10'h155, 10'h2aa, 16'h5555);
        send_pixel(10'h2aa, 10'h155, 16'h1555);
        send_pixel('1, '1, 1);
        send_random(RAND_PER_SET + 5);

        for (int p = 0; p < 7; p++) begin
            choose_config(pose_seq[p]);
            write_regs();
            no_gaps = (p % 2 == 1);
            if (pose_seq[p] == POSE_HIGH) begin
                // corners at the depth limit, most of them driving axes into saturation
                send_pixel(0, 0, DEPTH_W'(MAX_DEPTH));
                send_pixel('1, '1, DEPTH_W'(MAX_DEPTH));
                send_pixel(0, '1, DEPTH_W'(MAX_DEPTH));
                send_pixel('1, 0, DEPTH_W'(MAX_DEPTH));
            end
            send_random(RAND_PER_SET);
        end

        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS depth_pixel_backprojection_unit");
        else
            $display("FAIL depth_pixel_backprojection_unit");
        $finish;
    end

endmodule : depth_pixel_backprojection_unit_tb

// ----- depth_pixel_backprojection_unit.f -----
rtl/dpb_pkg.sv
rtl/dpb_if.sv
rtl/depth_pixel_backprojection_unit.sv
tb/sv/dpb_world_point_checker.sv
tb/sv/depth_pixel_backprojection_unit_tb.sv
